@@ rtl/grid_cell_detection_confirm_unit_macros.svh @@
// Assertion macros for the grid cell detection confirm unit.
// Each macro expects clk and rst_n in scope.
`ifndef GRID_CELL_DETECTION_CONFIRM_UNIT_MACROS_SVH
`define GRID_CELL_DETECTION_CONFIRM_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define GCDC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcdc assertion failed");

// Next-cycle implication, checked outside reset
`define GCDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcdc assertion failed");

`endif

@@ rtl/gcdc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gcdc_pkg;

    // Default geometry
    localparam int GRID_SIZE_DEF  = 15;
    localparam int COUNT_BITS_DEF = 4;

    // Item field widths
    localparam int POS_W = 4;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int THR_BITS   = 4;
    localparam logic [THR_BITS-1:0] THR_RESET = 4'd3;

    // Register index, taken from paddr[2]
    localparam logic REG_THRESHOLD = 1'b0;

    // Item commands
    localparam logic CMD_DETECT = 1'b0;
    localparam logic CMD_EOF    = 1'b1;

endpackage

`default_nettype wire

@@ rtl/gcdc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gcdc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 225
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/grid_cell_detection_confirm_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Signals                                   | Transfer when
// ----------+-------------------------------------------+------------------------------
// item in   | start, busy, cmd, cell_row, cell_col,      | start && !busy at clk rise
//           | is_white                                  |
// result    | piece_valid, piece_row, piece_col,         | piece_valid (one cycle)
//           | piece_white                               |
// config    | psel, penable, pwrite, paddr, pwdata,      | psel && penable && pwrite
//           | prdata, pready                            |
//
// One item per cycle; busy is always low. A confirmation reaches the result
// ports through the candidate RAM read, registered alongside the stage 1 registers,
// and then the update and the result register.
// Reset clears all per-cell flag vectors (candidate valid, seen, board occupied)
// at once; the candidate RAM needs no clearing pass.
// The result side cannot stall; nothing on the input side waits for it.

module grid_cell_detection_confirm_unit #(
    parameter int GRID_SIZE  = gcdc_pkg::GRID_SIZE_DEF,
    parameter int COUNT_BITS = gcdc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // item input
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            cmd,
    input  wire logic [gcdc_pkg::POS_W-1:0]      cell_row,
    input  wire logic [gcdc_pkg::POS_W-1:0]      cell_col,
    input  wire logic                            is_white,
    // result output
    output logic                                 piece_valid,
    output logic      [gcdc_pkg::POS_W-1:0]      piece_row,
    output logic      [gcdc_pkg::POS_W-1:0]      piece_col,
    output logic                                 piece_white,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [gcdc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [gcdc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [gcdc_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);

    import gcdc_pkg::*;

    `include "grid_cell_detection_confirm_unit_macros.svh"

    localparam int CELLS  = GRID_SIZE * GRID_SIZE;
    localparam int CELL_W = $clog2(CELLS);
    localparam int CMP_W  = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;
    localparam int RAM_W  = COUNT_BITS + 1;
    localparam logic [POS_W+1:0] GRID_LIM = (POS_W + 2)'(GRID_SIZE);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [THR_BITS-1:0] thr_reg;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_THRESHOLD))
        begin
            thr_reg <= pwdata[THR_BITS-1:0];
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_THRESHOLD)
        begin
            prdata = APB_DATA_W'(thr_reg);
        end
    end

    // ------------------------------------------------------------------
    // Input transfer and cell index
    // ------------------------------------------------------------------
    logic              accept;
    logic              in_grid;
    logic [CELL_W-1:0] in_idx;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign in_grid = ({2'b00, cell_row} < GRID_LIM) && ({2'b00, cell_col} < GRID_LIM);
    assign in_idx  = CELL_W'(cell_row) * CELL_W'(GRID_SIZE) + CELL_W'(cell_col);

    // ------------------------------------------------------------------
    // Stage 1 registers: item waiting for its RAM read data
    // ------------------------------------------------------------------
    logic              s1_valid_reg;
    logic              s1_cmd_reg;
    logic              s1_in_grid_reg;
    logic [POS_W-1:0]  s1_row_reg;
    logic [POS_W-1:0]  s1_col_reg;
    logic              s1_white_reg;
    logic [CELL_W-1:0] s1_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg     <= cmd;
            s1_in_grid_reg <= in_grid;
            s1_row_reg     <= cell_row;
            s1_col_reg     <= cell_col;
            s1_white_reg   <= is_white;
            s1_idx_reg     <= in_idx;
        end
    end

    // ------------------------------------------------------------------
    // Per-cell state: flags in flops, candidate colour/count in RAM
    // ------------------------------------------------------------------
    logic [CELLS-1:0] cand_valid_reg, cand_valid_next;
    logic [CELLS-1:0] seen_reg, seen_next;
    logic [CELLS-1:0] board_full_reg, board_full_next;

    logic             ram_we;
    logic [RAM_W-1:0] ram_wdata;
    logic [RAM_W-1:0] ram_rdata;

    gcdc_ram #(
        .WIDTH (RAM_W),
        .DEPTH (CELLS)
    ) u_cand_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_idx_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_idx),
        .rdata (ram_rdata)
    );

    // Forward the last write when the next item hits the same cell
    logic             fwd_hit_reg;
    logic [RAM_W-1:0] fwd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= accept && ram_we && (s1_idx_reg == in_idx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            fwd_data_reg <= ram_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Candidate update and confirmation
    // ------------------------------------------------------------------
    logic                  s1_det;
    logic                  s1_eof;
    logic [RAM_W-1:0]      cur_data;
    logic                  cur_valid;
    logic                  cur_white;
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] new_count;
    logic                  cand_match;
    logic                  confirm;

    assign s1_det    = s1_valid_reg && (s1_cmd_reg == CMD_DETECT) && s1_in_grid_reg;
    assign s1_eof    = s1_valid_reg && (s1_cmd_reg == CMD_EOF);
    assign cur_data  = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign cur_white = cur_data[COUNT_BITS];
    assign cur_count = cur_data[COUNT_BITS-1:0];
    assign cur_valid = s1_det && cand_valid_reg[s1_idx_reg];

    assign cand_match = cur_valid && (cur_white == s1_white_reg);

    // Saturating count, restart at one on a new candidate
    always_comb
    begin
        if (!cand_match)
        begin
            new_count = COUNT_BITS'(1);
        end
        else if (&cur_count)
        begin
            new_count = cur_count;
        end
        else
        begin
            new_count = cur_count + COUNT_BITS'(1);
        end
    end

    assign confirm = s1_det && (CMP_W'(new_count) >= CMP_W'(thr_reg))
                     && !board_full_reg[s1_idx_reg];

    assign ram_we    = s1_det;
    assign ram_wdata = {s1_white_reg, new_count};

    // Flag vector updates; end of frame drops unseen candidates
    always_comb
    begin
        cand_valid_next = cand_valid_reg;
        seen_next       = seen_reg;
        board_full_next = board_full_reg;
        if (s1_eof)
        begin
            cand_valid_next = cand_valid_reg & seen_reg;
            seen_next       = '0;
        end
        else if (s1_det)
        begin
            cand_valid_next[s1_idx_reg] = 1'b1;
            seen_next[s1_idx_reg]       = 1'b1;
            if (confirm)
            begin
                board_full_next[s1_idx_reg] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_valid_reg <= '0;
            seen_reg       <= '0;
            board_full_reg <= '0;
        end
        else
        begin
            cand_valid_reg <= cand_valid_next;
            seen_reg       <= seen_next;
            board_full_reg <= board_full_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic             piece_valid_reg;
    logic [POS_W-1:0] piece_row_reg;
    logic [POS_W-1:0] piece_col_reg;
    logic             piece_white_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            piece_valid_reg <= 1'b0;
        end
        else
        begin
            piece_valid_reg <= confirm;
        end
    end

    always_ff @(posedge clk)
    begin
        if (confirm)
        begin
            piece_row_reg   <= s1_row_reg;
            piece_col_reg   <= s1_col_reg;
            piece_white_reg <= s1_white_reg;
        end
    end

    assign piece_valid = piece_valid_reg;
    assign piece_row   = piece_row_reg;
    assign piece_col   = piece_col_reg;
    assign piece_white = piece_white_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `GCDC_ASSERT_SAME(a_result_from_detect, piece_valid_reg, $past(s1_det))
    `GCDC_ASSERT_NEXT(a_eof_clears_seen, s1_eof, seen_reg == '0)
    `GCDC_ASSERT_SAME(a_fwd_needs_item, fwd_hit_reg, s1_valid_reg)
    `GCDC_ASSERT_NEXT(a_board_sticky, confirm, board_full_reg != '0)

endmodule

`default_nettype wire
